/* rtl/core/sff_pkg.sv */
package sff_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 16;
    localparam int INDEX_W      = 7;
    localparam int SHIFT_W      = 5;
    localparam int TAPS_DEFAULT = 255;
    localparam int QUEUE_DEPTH  = 2;
    localparam int SAMPLE_MAX   = 32767;
    localparam int SAMPLE_MIN   = -32768;

    localparam logic [SHIFT_W-1:0] OUT_SHIFT_RESET = SHIFT_W'(15);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    typedef struct packed {
        logic                       is_load;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

/* rtl/core/sff_ram.sv */
module sff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    output logic [WIDTH-1:0]         o_rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* rtl/core/sff_front.sv */
module sff_front #(
    parameter int TAPS = sff_pkg::TAPS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic signed [sff_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [sff_pkg::INDEX_W-1:0]        i_coef_index,
    input  logic signed [sff_pkg::COEF_W-1:0]  i_coef_value,
    input  sff_pkg::t_back_status              i_status,
    input  logic                               i_pop,
    output sff_pkg::t_queue_out                o_queue
);

    import sff_pkg::*;

    localparam int COEF_DEPTH = TAPS / 2 + 1;
    localparam int QP_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

    t_item              r_q [QUEUE_DEPTH];
    logic [QP_W-1:0]    r_wr_ptr;
    logic [QP_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [QP_W-1:0]    n_wr_ptr;
    logic [QP_W-1:0]    n_rd_ptr;
    logic [CNT_W-1:0]   n_count;

    t_item              item;
    logic               full;
    logic               accept;
    logic               keep;
    logic               push;

    always_comb begin
        item.is_load    = (i_req_type == REQ_LOAD);
        item.sample     = i_sample_in;
        item.coef_index = i_coef_index;
        item.coef_value = i_coef_value;
    end

    assign full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_in_stall = full || i_status.clearing;
    assign accept     = i_in_valid && !o_in_stall;
    // drop loads aimed past the stored half of the coefficients
    assign keep       = !item.is_load || (32'(i_coef_index) < COEF_DEPTH);
    assign push       = accept && keep;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    assign o_queue.valid = (r_count != '0);
    assign o_queue.item  = r_q[r_rd_ptr];

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");
`endif

endmodule

/* rtl/core/sff_back.sv */
module sff_back #(
    parameter int TAPS = sff_pkg::TAPS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sff_pkg::t_queue_out                 i_queue,
    output logic                                o_pop,
    output sff_pkg::t_back_status               o_status,
    input  logic [sff_pkg::SHIFT_W-1:0]         i_out_shift,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [sff_pkg::SAMPLE_W-1:0] o_sample_out
);

    import sff_pkg::*;

    localparam int HALF       = TAPS / 2;
    localparam int COEF_DEPTH = HALF + 1;
    localparam int DL_AW      = $clog2(TAPS);
    localparam int CF_AW      = $clog2(COEF_DEPTH);
    localparam int PAIR_W     = SAMPLE_W + 1;
    localparam int PROD_W     = PAIR_W + COEF_W;
    localparam int ACC_W      = PROD_W + CF_AW + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ISSUE = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                 r_state, n_state;
    logic [DL_AW-1:0]           r_clr, n_clr;
    logic [DL_AW-1:0]           r_pos, n_pos;
    logic [DL_AW-1:0]           r_pa, n_pa;
    logic [DL_AW-1:0]           r_pb, n_pb;
    logic [CF_AW-1:0]           r_idx, n_idx;
    logic                       r_v1, n_v1;
    logic                       r_c1, n_c1;
    logic                       r_v2, n_v2;
    logic                       r_v3, n_v3;
    logic signed [PAIR_W-1:0]   r_pair, n_pair;
    logic signed [COEF_W-1:0]   r_coef, n_coef;
    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic signed [ACC_W-1:0]    r_shifted, n_shifted;
    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample_out, n_sample_out;

    logic                       dl_we;
    logic [DL_AW-1:0]           dl_waddr;
    logic [SAMPLE_W-1:0]        dl_wdata;
    logic [SAMPLE_W-1:0]        dl_rd_a;
    logic [SAMPLE_W-1:0]        dl_rd_b;
    logic                       cf_we;
    logic [CF_AW-1:0]           cf_waddr;
    logic [COEF_W-1:0]          cf_wdata;
    logic [COEF_W-1:0]          cf_rd;
    logic [DL_AW-1:0]           pos_next;
    logic                       last_step;

    sff_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAPS)
    ) u_delay_line (
        .i_clk       (i_clk),
        .i_wr_en     (dl_we),
        .i_wr_addr   (dl_waddr),
        .i_wr_data   (dl_wdata),
        .i_rd_addr_a (r_pa),
        .o_rd_data_a (dl_rd_a),
        .i_rd_addr_b (r_pb),
        .o_rd_data_b (dl_rd_b)
    );

    sff_ram #(
        .WIDTH (COEF_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_store (
        .i_clk       (i_clk),
        .i_wr_en     (cf_we),
        .i_wr_addr   (cf_waddr),
        .i_wr_data   (cf_wdata),
        .i_rd_addr_a (r_idx),
        .o_rd_data_a (cf_rd),
        .i_rd_addr_b (r_idx),
        .o_rd_data_b ()
    );

    assign pos_next  = (r_pos == DL_AW'(TAPS - 1)) ? '0 : r_pos + 1'b1;
    assign last_step = (r_idx == CF_AW'(HALF));

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_pos        = r_pos;
        n_pa         = r_pa;
        n_pb         = r_pb;
        n_idx        = r_idx;
        n_shifted    = r_shifted;
        n_sample_out = r_sample_out;
        n_out_valid  = r_out_valid;

        dl_we    = 1'b0;
        dl_waddr = r_pos;
        dl_wdata = i_queue.item.sample;
        cf_we    = 1'b0;
        cf_waddr = CF_AW'(i_queue.item.coef_index);
        cf_wdata = i_queue.item.coef_value;
        o_pop    = 1'b0;

        // MAC pipeline: pair sum, product, accumulate
        n_v1   = 1'b0;
        n_c1   = r_c1;
        n_v2   = r_v1;
        n_pair = r_c1 ? PAIR_W'($signed(dl_rd_a))
                      : PAIR_W'($signed(dl_rd_a)) + PAIR_W'($signed(dl_rd_b));
        n_coef = $signed(cf_rd);
        n_v3   = r_v2;
        n_prod = r_pair * r_coef;
        n_acc  = r_acc;
        if (r_v3) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                dl_we    = 1'b1;
                dl_waddr = r_clr;
                dl_wdata = '0;
                cf_we    = (32'(r_clr) < COEF_DEPTH);
                cf_waddr = CF_AW'(r_clr);
                cf_wdata = '0;
                if (r_clr == DL_AW'(TAPS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_queue.valid) begin
                    o_pop = 1'b1;
                    if (i_queue.item.is_load) begin
                        cf_we = 1'b1;
                    end else begin
                        // write the new sample, then walk pairs inward from both ends
                        dl_we   = 1'b1;
                        n_pa    = r_pos;
                        n_pb    = pos_next;
                        n_pos   = pos_next;
                        n_idx   = '0;
                        n_acc   = '0;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                n_v1  = 1'b1;
                n_c1  = last_step;
                n_pa  = (r_pa == '0) ? DL_AW'(TAPS - 1) : r_pa - 1'b1;
                n_pb  = (r_pb == DL_AW'(TAPS - 1)) ? '0 : r_pb + 1'b1;
                n_idx = r_idx + 1'b1;
                if (last_step) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                n_shifted = r_acc >>> i_out_shift;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    if (r_shifted > SAT_HI) begin
                        n_sample_out = SAMPLE_W'(SAMPLE_MAX);
                    end else if (r_shifted < SAT_LO) begin
                        n_sample_out = SAMPLE_W'(SAMPLE_MIN);
                    end else begin
                        n_sample_out = r_shifted[SAMPLE_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pos       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pos       <= n_pos;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_v3        <= n_v3;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa         <= n_pa;
        r_pb         <= n_pb;
        r_idx        <= n_idx;
        r_c1         <= n_c1;
        r_pair       <= n_pair;
        r_coef       <= n_coef;
        r_prod       <= n_prod;
        r_acc        <= n_acc;
        r_shifted    <= n_shifted;
        r_sample_out <= n_sample_out;
    end

    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_sample_out;

`ifndef SYNTH
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_v1 && !r_v2 && !r_v3)
        else $error("MAC pipeline busy while idle");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE && i_queue.valid)
        else $error("item popped outside idle");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= DL_AW'(TAPS - 1))
        else $error("write position past delay line");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && (!r_out_valid || !i_out_stall)
        |=> r_out_valid && r_state == S_IDLE)
        else $error("result not loaded into output register");
`endif

endmodule

/* rtl/core/symmetric_fir_filter.sv */
// Odd-length linear-phase FIR filter for signed 16-bit audio. A sample item is
// written into a circular delay line of TAPS entries, then a single shared
// multiply-accumulate walks the mirrored sample pairs, one pair per cycle,
// against the stored half of the Q1.15 coefficients, adds the center tap,
// shifts the sum right (floor) by out_shift and saturates to 16 bits. A
// sample passes the issue, drain, shift and out states from leaving the input
// queue to entering the output register, the issue state stepping the one MAC
// through the pairs; a coefficient load is written while idle, with no result.
// A two-entry queue sits behind the input, so up to two items are taken
// while a sample is in progress or a result waits. After reset a clearing
// pass of TAPS writes zeros both memories; the input stalls until it ends.
// The out_shift register (reset 15) is always ready; write it only while the
// filter is idle.
module symmetric_fir_filter #(
    parameter int TAPS = sff_pkg::TAPS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic signed [sff_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [sff_pkg::INDEX_W-1:0]         i_coef_index,
    input  logic signed [sff_pkg::COEF_W-1:0]   i_coef_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [sff_pkg::SAMPLE_W-1:0] o_sample_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sff_pkg::SHIFT_W-1:0]         i_cfg_data
);

    import sff_pkg::*;

    logic [SHIFT_W-1:0] r_out_shift;
    logic [SHIFT_W-1:0] n_out_shift;
    t_queue_out         queue;
    t_back_status       status;
    logic               pop;

    assign o_cfg_ready = 1'b1;
    assign n_out_shift = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_out_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_shift <= OUT_SHIFT_RESET;
        end else begin
            r_out_shift <= n_out_shift;
        end
    end

    sff_front #(
        .TAPS (TAPS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_status     (status),
        .i_pop        (pop),
        .o_queue      (queue)
    );

    sff_back #(
        .TAPS (TAPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue      (queue),
        .o_pop        (pop),
        .o_status     (status),
        .i_out_shift  (r_out_shift),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out)
    );

endmodule

/* test/symmetric_fir_filter_tb.sv */
`timescale 1ns / 100ps

module symmetric_fir_filter_tb;
    import sff_pkg::*;

    localparam int TAPS         = TAPS_DEFAULT;
    localparam int HALF         = TAPS / 2;
    localparam int SETTLE_CYCLES = 200;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic                       o_in_stall;
    logic                       i_req_type   = REQ_SAMPLE;
    logic signed [SAMPLE_W-1:0] i_sample_in  = '0;
    logic [INDEX_W-1:0]         i_coef_index = '0;
    logic signed [COEF_W-1:0]   i_coef_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall  = 1'b0;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       i_cfg_valid  = 1'b0;
    logic                       o_cfg_ready;
    logic [SHIFT_W-1:0]         i_cfg_data   = '0;

    // filter state as the testbench sees it
    logic signed [SAMPLE_W-1:0] history [TAPS];
    logic signed [COEF_W-1:0]   coefs [HALF+1];
    int unsigned                head_pos;
    logic [SHIFT_W-1:0]         scale_shift;

    t_item                      pending_items[$];
    t_item                      driven_item;
    logic signed [SAMPLE_W-1:0] expected_samples[$];

    int                         tx_idle_pct = 38;
    int                         rx_stall_pct = 38;
    int                         error_count = 0;
    logic                       shift_request = 1'b0;
    logic [SHIFT_W-1:0]         shift_value = '0;

    symmetric_fir_filter #(.TAPS(TAPS)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_sample_in  (i_sample_in),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one accepted item: load a coefficient or filter a sample.
    function automatic void filter_item(input t_item it);
        logic signed [63:0] acc;
        logic signed [63:0] newer;
        logic signed [63:0] older;
        logic signed [63:0] weight;
        int unsigned        now;
        int                 i;
        if (it.is_load) begin
            if (it.coef_index <= HALF)
                coefs[it.coef_index] = it.coef_value;
            return;
        end
        now = head_pos;
        history[now] = it.sample;
        acc = '0;
        // pair x[n-i] with its mirror x[n-TAPS+1+i]
        for (i = 0; i < HALF; i++) begin
            newer  = history[(now + TAPS - i) % TAPS];
            older  = history[(now + 1 + i) % TAPS];
            weight = coefs[i];
            acc += (newer + older) * weight;
        end
        newer  = history[(now + TAPS - HALF) % TAPS];
        weight = coefs[HALF];
        acc += newer * weight;
        acc = acc >>> scale_shift;
        if (acc > SAMPLE_MAX)
            acc = SAMPLE_MAX;
        if (acc < SAMPLE_MIN)
            acc = SAMPLE_MIN;
        expected_samples.push_back(acc[SAMPLE_W-1:0]);
        head_pos = (now + 1) % TAPS;
    endfunction

    function automatic logic signed [15:0] rand_word();
        case ($urandom_range(15))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_sample(input int value);
        t_item it;
        it.is_load    = 1'b0;
        it.sample     = SAMPLE_W'(value);
        it.coef_index = INDEX_W'($urandom);
        it.coef_value = rand_word();
        pending_items.push_back(it);
    endtask

    task automatic queue_load(input int slot, input int value);
        t_item it;
        it.is_load    = 1'b1;
        it.sample     = rand_word();
        it.coef_index = INDEX_W'(slot);
        it.coef_value = COEF_W'(value);
        pending_items.push_back(it);
    endtask

    task automatic queue_random(input int count);
        t_item it;
        int    k;
        for (k = 0; k < count; k++) begin
            it.is_load    = ($urandom_range(99) < 15);
            it.sample     = rand_word();
            it.coef_index = ($urandom_range(9) == 0) ? INDEX_W'($urandom_range(1) * HALF)
                                                     : INDEX_W'($urandom_range(HALF));
            it.coef_value = rand_word();
            pending_items.push_back(it);
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_samples.size() != 0)
            @(negedge i_clk);
    endtask

    // Write out_shift only once the filter has gone quiet.
    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        shift_value   = value;
        shift_request = 1'b1;
        while (shift_request)
            @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                filter_item(driven_item);
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    driven_item = pending_items.pop_front();
                    i_req_type   <= driven_item.is_load ? REQ_LOAD : REQ_SAMPLE;
                    i_sample_in  <= driven_item.sample;
                    i_coef_index <= driven_item.coef_index;
                    i_coef_value <= driven_item.coef_value;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                scale_shift   = i_cfg_data;
                shift_request = 1'b0;
                i_cfg_valid  <= 1'b0;
            end else if (shift_request && !i_cfg_valid) begin
                i_cfg_data  <= shift_value;
                i_cfg_valid <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        logic signed [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_samples.size() == 0) begin
                    $error("sample_out with no item pending: actual %0d", o_sample_out);
                    error_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (o_sample_out !== want) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want, o_sample_out);
                        error_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    initial begin : stimulus
        int                 p;
        int                 i;
        logic [SHIFT_W-1:0] phase_shift;
        for (i = 0; i < TAPS; i++)
            history[i] = '0;
        for (i = 0; i <= HALF; i++)
            coefs[i] = '0;
        head_pos    = 0;
        scale_shift = OUT_SHIFT_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset shift: extreme coefficients, full-scale samples, floor on negatives
        queue_load(HALF, SAMPLE_MAX);
        queue_load(0, SAMPLE_MIN);
        queue_load(1, 1);
        queue_load(HALF - 1, -1);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(-1);
        queue_sample(1);
        queue_sample(0);
        queue_sample(100);
        queue_sample(-100);

        // no scaling: saturate both ways
        write_shift(5'd0);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(5);
        queue_sample(-5);

        // full scaling: everything floors to 0 or -1
        write_shift(5'd31);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        queue_sample(1);

        for (p = 0; p < 8; p++) begin
            case (p)
                0: phase_shift = 5'd15;
                1: phase_shift = 5'd22;
                2: phase_shift = 5'd0;
                3: phase_shift = 5'd31;
                4: phase_shift = 5'd18;
                5: phase_shift = 5'd24;
                6: phase_shift = 5'd20;
                default: phase_shift = SHIFT_W'($urandom_range(31));
            endcase
            write_shift(phase_shift);
            tx_idle_pct  = (p == 5) ? 0 : 38;
            rx_stall_pct = (p == 5) ? 0 : 38;
            if (p == 3) begin
                // hold the sender until every result is back
                queue_random(68);
                wait_drained();
                queue_random(68);
            end else begin
                queue_random(136);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (expected_samples.size() != 0) begin
            $error("%0d sample_out results never arrived", expected_samples.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
